// ===== rtl/core/sfld_pkg.sv =====
// Shared constants, types and the CRC step function of the framed log demultiplexer.
`default_nettype none

package sfld_pkg;

   localparam int HEADER_BYTES        = 10;
   localparam int HDR_IDX_W           = $clog2(HEADER_BYTES);
   localparam int MAX_PAYLOAD_DEFAULT = 1023;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_DATA_W          = 10;
   localparam int CSR_INDEX_W         = 2;
   localparam int INDEX_W             = 10;

   localparam logic [15:0] SYNC_WORD   = 16'hA55A;
   localparam logic [7:0]  SYNC_FIRST  = SYNC_WORD[7:0];
   localparam logic [7:0]  SYNC_SECOND = SYNC_WORD[15:8];
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_TOP     = 16'h8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOG_ENABLE       = 2'd0,
      CSR_EXPECTED_VERSION = 2'd1,
      CSR_EXPECTED_TYPE    = 2'd2,
      CSR_PAYLOAD_LENGTH   = 2'd3
   } sfld_csr_type;

   typedef enum logic [2:0] {
      KIND_PASS    = 3'd0,
      KIND_PAYLOAD = 3'd1,
      KIND_GOOD    = 3'd2,
      KIND_BADCRC  = 3'd3,
      KIND_DROP    = 3'd4
   } sfld_kind_type;

   // Work orders handed from the parser to the result generator.
   typedef enum logic [2:0] {
      OP_PASS    = 3'd0,  // one passthrough byte
      OP_PASS2   = 3'd1,  // the first sync byte given back, then the byte itself
      OP_REPLAY  = 3'd2,  // the whole rejected header given back
      OP_PAYLOAD = 3'd3,  // one payload byte
      OP_STATUS  = 3'd4   // closing status of a frame
   } sfld_op_type;

   typedef struct packed {
      logic                 log_enable;
      logic [7:0]           expected_version;
      logic [7:0]           expected_type;
      logic [INDEX_W-1:0]   payload_length;
   } sfld_cfg_type;

   typedef logic [HEADER_BYTES-1:0][7:0] sfld_hdr_type;

   typedef struct packed {
      sfld_op_type        op;
      sfld_kind_type      kind;
      logic [7:0]         data;
      logic [INDEX_W-1:0] idx;
      logic [31:0]        seq;
      sfld_hdr_type       hdr;
   } sfld_cmd_type;

   // CRC-16/CCITT-FALSE over one byte, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfld_if.sv =====
// Valid/ready channel interfaces for received bytes and for results.
`default_nettype none

interface sfld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfld_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [9:0]  payload_index;
   logic [31:0] sequence_res;
   logic        last;

   modport source (output valid, output kind, output data_byte, output payload_index,
                   output sequence_res, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input payload_index,
                   input sequence_res, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sfld_queue.sv =====
// Short command queue between the frame parser and the result generator.
`default_nettype none

module sfld_queue
   import sfld_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire sfld_cmd_type push_cmd,
   output logic              full,
   input  wire logic         pop,
   output sfld_cmd_type      head,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfld_cmd_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sfld_front.sv =====
// Frame parser: tracks sync, header, payload and CRC and issues result commands.
`default_nettype none

module sfld_front
   import sfld_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sfld_cfg_type cfg,
   input  wire logic         accept,
   input  wire logic [7:0]   rx_byte,
   output logic              push,
   output sfld_cmd_type      push_cmd
);

   localparam int POS_W = $clog2(MAX_PAYLOAD + 2);
   localparam logic [15:0] LEN_LIMIT = 16'(MAX_PAYLOAD);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SYNC1,
      PH_HEADER,
      PH_BODY
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [HDR_IDX_W-1:0]   cnt_ff, cnt_in;
   sfld_hdr_type           hdr_ff, hdr_in;
   logic [15:0]            crc_ff, crc_in;
   logic [7:0]             crc_low_ff, crc_low_in;
   logic [31:0]            seq_ff, seq_in;
   logic [POS_W-1:0]       len_ff, len_in;
   logic [POS_W-1:0]       pos_ff, pos_in;

   logic [15:0]            crc_next;
   logic [15:0]            crc_first;
   sfld_hdr_type           hdr_full;
   logic [15:0]            len_hdr;
   logic                   hdr_bad;
   logic [POS_W+15:0]      len_wide;
   logic [POS_W+INDEX_W-1:0] pos_wide;

   assign crc_next  = crc_byte(crc_ff, rx_byte);
   assign crc_first = crc_byte(CRC_INIT, rx_byte);
   assign len_hdr   = {hdr_ff[5], hdr_ff[4]};
   assign len_wide  = {{POS_W{1'b0}}, len_hdr};
   assign pos_wide  = {{INDEX_W{1'b0}}, pos_ff};
   assign hdr_bad   = (hdr_ff[2] != cfg.expected_version) ||
                      (hdr_ff[3] != cfg.expected_type) ||
                      (len_hdr != {6'b000000, cfg.payload_length}) ||
                      (len_hdr > LEN_LIMIT);

   always_comb begin
      hdr_full                 = hdr_ff;
      hdr_full[HEADER_BYTES-1] = rx_byte;
   end

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      hdr_in     = hdr_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;

      push          = 1'b0;
      push_cmd.op   = OP_PASS;
      push_cmd.kind = KIND_PASS;
      push_cmd.data = rx_byte;
      push_cmd.idx  = pos_wide[INDEX_W-1:0];
      push_cmd.seq  = seq_ff;
      push_cmd.hdr  = hdr_full;

      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (rx_byte == SYNC_FIRST) begin
                  hdr_in[0] = rx_byte;
                  cnt_in    = HDR_IDX_W'(1);
                  crc_in    = crc_first;
                  phase_in  = PH_SYNC1;
               end else begin
                  push = 1'b1;
               end
            end
            PH_SYNC1: begin
               if (rx_byte == SYNC_SECOND) begin
                  hdr_in[1] = rx_byte;
                  cnt_in    = HDR_IDX_W'(2);
                  crc_in    = crc_next;
                  phase_in  = PH_HEADER;
               end else if (rx_byte == SYNC_FIRST) begin
                  // The earlier sync byte goes out; this one opens a new frame.
                  push      = 1'b1;
                  hdr_in[0] = rx_byte;
                  cnt_in    = HDR_IDX_W'(1);
                  crc_in    = crc_first;
               end else begin
                  push        = 1'b1;
                  push_cmd.op = OP_PASS2;
                  cnt_in      = '0;
                  phase_in    = PH_IDLE;
               end
            end
            PH_HEADER: begin
               hdr_in[cnt_ff] = rx_byte;
               crc_in         = crc_next;
               cnt_in         = cnt_ff + 1'b1;
               if (cnt_ff == HDR_IDX_W'(HEADER_BYTES - 1)) begin
                  if (hdr_bad) begin
                     push        = 1'b1;
                     push_cmd.op = OP_REPLAY;
                     cnt_in      = '0;
                     phase_in    = PH_IDLE;
                  end else begin
                     seq_in   = {hdr_full[9], hdr_full[8], hdr_full[7], hdr_full[6]};
                     len_in   = len_wide[POS_W-1:0];
                     pos_in   = '0;
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (pos_ff < len_ff) begin
                  crc_in      = crc_next;
                  pos_in      = pos_ff + 1'b1;
                  push        = cfg.log_enable;
                  push_cmd.op = OP_PAYLOAD;
               end else if (pos_ff == len_ff) begin
                  crc_low_in = rx_byte;
                  pos_in     = pos_ff + 1'b1;
               end else begin
                  push        = 1'b1;
                  push_cmd.op = OP_STATUS;
                  if (!cfg.log_enable) begin
                     push_cmd.kind = KIND_DROP;
                  end else if ({rx_byte, crc_low_ff} == crc_ff) begin
                     push_cmd.kind = KIND_GOOD;
                  end else begin
                     push_cmd.kind = KIND_BADCRC;
                  end
                  cnt_in   = '0;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               cnt_in   = '0;
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cnt_ff     <= '0;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= '0;
         seq_ff     <= '0;
         len_ff     <= '0;
         pos_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         seq_ff     <= seq_in;
         len_ff     <= len_in;
         pos_ff     <= pos_in;
      end
      hdr_ff <= hdr_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/sfld_back.sv =====
// Result generator: expands queued commands into results behind an output register.
`default_nettype none

module sfld_back
   import sfld_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sfld_cmd_type head,
   input  wire logic         empty,
   output logic              pop,
   sfld_rsp_if.source        rsp
);

   sfld_cmd_type          cmd_ff, cmd_in;
   logic                  busy_ff, busy_in;
   logic [HDR_IDX_W-1:0]  step_ff, step_in;

   logic                  valid_ff, valid_in;
   sfld_kind_type         kind_ff, kind_in;
   logic [7:0]            data_ff, data_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;
   logic [31:0]           seq_ff, seq_in;
   logic                  last_ff, last_in;

   sfld_cmd_type          cur;
   logic [HDR_IDX_W-1:0]  step;
   logic                  have;
   logic                  slot_free;
   logic                  advance;
   sfld_kind_type         el_kind;
   logic [7:0]            el_data;
   logic [INDEX_W-1:0]    el_idx;
   logic [31:0]           el_seq;
   logic                  el_last;

   assign cur       = busy_ff ? cmd_ff : head;
   assign step      = busy_ff ? step_ff : '0;
   assign have      = busy_ff || !empty;
   assign slot_free = !valid_ff || rsp.ready;
   assign advance   = slot_free && have;
   assign pop       = advance && !busy_ff;

   // One result of the current command, selected by the step count.
   always_comb begin
      el_kind = KIND_PASS;
      el_data = cur.data;
      el_idx  = '0;
      el_seq  = '0;
      el_last = 1'b1;
      case (cur.op)
         OP_PASS: begin
            el_last = 1'b1;
         end
         OP_PASS2: begin
            if (step == '0) begin
               el_data = SYNC_FIRST;
               el_last = 1'b0;
            end
         end
         OP_REPLAY: begin
            el_data = cur.hdr[step];
            el_last = (step == HDR_IDX_W'(HEADER_BYTES - 1));
         end
         OP_PAYLOAD: begin
            el_kind = KIND_PAYLOAD;
            el_idx  = cur.idx;
            el_seq  = cur.seq;
         end
         OP_STATUS: begin
            el_kind = cur.kind;
            el_data = '0;
            el_seq  = cur.seq;
         end
         default: begin
            el_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      cmd_in   = cmd_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      data_in  = data_ff;
      idx_in   = idx_ff;
      seq_in   = seq_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         kind_in  = el_kind;
         data_in  = el_data;
         idx_in   = el_idx;
         seq_in   = el_seq;
         last_in  = el_last;
         if (el_last) begin
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            cmd_in  = cur;
            step_in = step + 1'b1;
         end
      end else if (slot_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
      cmd_ff  <= cmd_in;
      kind_ff <= kind_in;
      data_ff <= data_in;
      idx_ff  <= idx_in;
      seq_ff  <= seq_in;
      last_ff <= last_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.data_byte     = data_ff;
   assign rsp.payload_index = idx_ff;
   assign rsp.sequence_res  = seq_ff;
   assign rsp.last          = last_ff;

   // A result that is not the last of its byte always leaves the rest in hand.
   a_pending_rest: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> busy_ff)
      else $error("non-final result shown without a command in progress");

   // Only multi-result commands are ever held over.
   a_held_op: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cmd_ff.op == OP_PASS2 || cmd_ff.op == OP_REPLAY))
      else $error("single-result command held over");

   // A header replay in progress points inside the header.
   a_replay_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cmd_ff.op == OP_REPLAY) |->
         (step_ff != '0 && step_ff <= HDR_IDX_W'(HEADER_BYTES - 1)))
      else $error("header replay step out of range");

   // A new command is taken only after the previous one has finished.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!busy_ff && !empty))
      else $error("command taken while another is in progress or none waits");

endmodule

`default_nettype wire

// ===== rtl/core/sync_framed_log_demux.sv =====
// Top level of the framed log demultiplexer: configuration registers, parser, queue, results.
//
// The block takes received bytes on req_ch (valid/ready, field rx_byte) and gives results on
// rsp_ch (valid/ready, fields kind, data_byte, payload_index, sequence_res, last). Bytes outside
// a frame come back as passthrough items; while logging is on, payload bytes come out as they
// arrive, each with its index and the frame sequence; one status item closes every frame as
// good, bad CRC or dropped. The final item caused by one received byte carries last = 1. Header
// bytes and the CRC low byte cause no item until the frame is decided.
// The parser takes one byte per cycle while its command queue (two entries) has room. The result
// generator sends one item per cycle from its output register while rsp_ch.ready lets it. Most
// bytes give one item, so the sustained rate is one byte per cycle; a rejected header gives back
// ten items for its last byte. Items pass through the queue and then the output register.
// When the receiver holds rsp_ch.ready low, the output register holds its item, the queue fills
// and req_ch.ready then falls; no item is lost. Synchronous reset returns the parser to waiting
// for the first sync byte, empties the queue and the output register, and loads the registers
// with their defaults: logging on, version 1, type 1, payload length 324. The user must write
// the registers through csr_we, csr_index and csr_wdata while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module sync_framed_log_demux
   import sfld_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   sfld_req_if.sink                    req_ch,
   sfld_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers; each write takes the low bits that the register holds.
   sfld_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sfld_csr_type'(csr_index))
            CSR_LOG_ENABLE:       cfg_in.log_enable       = csr_wdata[0];
            CSR_EXPECTED_VERSION: cfg_in.expected_version = csr_wdata[7:0];
            CSR_EXPECTED_TYPE:    cfg_in.expected_type    = csr_wdata[7:0];
            CSR_PAYLOAD_LENGTH:   cfg_in.payload_length   = csr_wdata[INDEX_W-1:0];
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log_enable       <= 1'b1;
         cfg_ff.expected_version <= 8'd1;
         cfg_ff.expected_type    <= 8'd1;
         cfg_ff.payload_length   <= INDEX_W'(324);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The parser may take a byte whenever the queue can hold the command it might issue.
   logic         q_full;
   logic         q_empty;
   logic         q_push;
   logic         q_pop;
   sfld_cmd_type q_push_cmd;
   sfld_cmd_type q_head;
   logic         accept;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;

   sfld_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .rx_byte  (req_ch.rx_byte),
      .push     (q_push),
      .push_cmd (q_push_cmd)
   );

   sfld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   sfld_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (q_head),
      .empty (q_empty),
      .pop   (q_pop),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench of the framed log demultiplexer: byte driver, result monitor, predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sfld_pkg::*;

   // Cycles allowed for the block to go quiet after the last item that can cause no result.
   localparam int SETTLE_CYCLES = 40;
   // Far above the length of any correct run.
   localparam int CYCLE_LIMIT   = 1_000_000;

   // Where the predictor stands in the received byte stream.
   typedef enum logic [1:0] {
      SEEK_FIRST,
      SEEK_SECOND,
      IN_HEADER,
      IN_BODY
   } parse_phase_type;

   typedef struct packed {
      sfld_kind_type      kind;
      logic [7:0]         data;
      logic [INDEX_W-1:0] idx;
      logic [31:0]        seq;
      logic               last;
   } demux_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sfld_req_if req_ch ();
   sfld_rsp_if rsp_ch ();

   sync_framed_log_demux dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the parser as the block should hold it, plus its own copy of the registers.
   parse_phase_type hunt;
   logic [7:0]      hdr_copy [HEADER_BYTES];
   logic [10:0]     frame_count;
   logic [15:0]     crc_run;
   logic [7:0]      crc_low;
   logic [31:0]     seq_now;
   sfld_cfg_type    cfg_now;

   demux_result_type step_out[$];     // results of the byte being predicted
   demux_result_type results_due[$];  // results predicted but not yet seen on the output
   logic [7:0]       rx_bytes_pending[$];

   int bytes_queued;
   int bytes_accepted;
   int results_seen;
   int error_count;
   int frames_good;
   int frames_bad;
   int frames_dropped;
   int headers_returned;
   int settings_used;
   int cycle_count;

   // Idling controls: percentage chance per cycle that a burst of idling starts.
   int src_gap_pct;
   int sink_stall_pct;
   int send_gap;
   int take_gap;

   // CRC-16/CCITT-FALSE, worked one bit at a time with the data bit folded into the feedback.
   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int k = 7; k >= 0; k--) begin
         if (r[15] ^ b[k]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Random byte with the sync values made more likely, so that they turn up inside frames too.
   function automatic logic [7:0] rand_byte();
      logic [7:0] b;
      b = 8'($urandom);
      case ($urandom_range(0, 9))
         0: b = SYNC_FIRST;
         1: b = SYNC_SECOND;
         default: ;
      endcase
      return b;
   endfunction

   task automatic note_result(input sfld_kind_type kind, input logic [7:0] data,
                              input logic [INDEX_W-1:0] idx, input logic [31:0] seq);
      demux_result_type r;
      r.kind = kind;
      r.data = data;
      r.idx  = idx;
      r.seq  = seq;
      r.last = 1'b0;
      step_out = {step_out, r};
   endtask

   // A byte seen while hunting for the first sync byte.
   task automatic idle_byte_model(input logic [7:0] b);
      if (b == SYNC_FIRST) begin
         hdr_copy[0] = b;
         frame_count = 11'd1;
         crc_run     = crc16_next(CRC_INIT, b);
         hunt        = SEEK_SECOND;
      end else begin
         note_result(KIND_PASS, b, '0, '0);
      end
   endtask

   // Works out the results that one accepted byte causes and queues them as expected.
   task automatic model_byte(input logic [7:0] b);
      logic [15:0]      hdr_len;
      logic [10:0]      pos;
      sfld_kind_type    close_kind;
      demux_result_type r;
      step_out.delete();
      hdr_len = {hdr_copy[5], hdr_copy[4]};
      case (hunt)
         SEEK_FIRST: idle_byte_model(b);
         SEEK_SECOND: begin
            if (b == SYNC_SECOND) begin
               hdr_copy[1] = b;
               frame_count = 11'd2;
               crc_run     = crc16_next(crc_run, b);
               hunt        = IN_HEADER;
            end else begin
               // False sync: the first sync byte goes back out and this byte is looked at afresh.
               note_result(KIND_PASS, SYNC_FIRST, '0, '0);
               hunt        = SEEK_FIRST;
               frame_count = '0;
               idle_byte_model(b);
            end
         end
         IN_HEADER: begin
            hdr_copy[frame_count] = b;
            crc_run     = crc16_next(crc_run, b);
            frame_count = frame_count + 1'b1;
            if (frame_count == HEADER_BYTES) begin
               hdr_len = {hdr_copy[5], hdr_copy[4]};
               if (hdr_copy[2] != cfg_now.expected_version ||
                   hdr_copy[3] != cfg_now.expected_type ||
                   hdr_len != 16'(cfg_now.payload_length) ||
                   hdr_len > MAX_PAYLOAD_DEFAULT) begin
                  // Rejected header: all ten bytes are handed back in order.
                  foreach (hdr_copy[i]) begin
                     note_result(KIND_PASS, hdr_copy[i], '0, '0);
                  end
                  headers_returned++;
                  hunt        = SEEK_FIRST;
                  frame_count = '0;
               end else begin
                  seq_now = {hdr_copy[9], hdr_copy[8], hdr_copy[7], hdr_copy[6]};
                  hunt    = IN_BODY;
               end
            end
         end
         IN_BODY: begin
            // The length comes from the stored header, not from the register.
            pos         = frame_count - 11'(HEADER_BYTES);
            frame_count = frame_count + 1'b1;
            if (pos < hdr_len) begin
               crc_run = crc16_next(crc_run, b);
               if (cfg_now.log_enable) begin
                  note_result(KIND_PAYLOAD, b, pos[INDEX_W-1:0], seq_now);
               end
            end else if (pos == hdr_len) begin
               crc_low = b;
            end else begin
               if (!cfg_now.log_enable) begin
                  close_kind = KIND_DROP;
                  frames_dropped++;
               end else if ({b, crc_low} == crc_run) begin
                  close_kind = KIND_GOOD;
                  frames_good++;
               end else begin
                  close_kind = KIND_BADCRC;
                  frames_bad++;
               end
               note_result(close_kind, 8'h00, '0, seq_now);
               hunt        = SEEK_FIRST;
               frame_count = '0;
            end
         end
         default: ;
      endcase
      if (step_out.size() > 0) begin
         r = step_out[step_out.size() - 1];
         r.last = 1'b1;
         step_out[step_out.size() - 1] = r;
      end
      results_due = {results_due, step_out};
   endtask

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Byte driver: presents queued bytes, holding each one until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= '0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            model_byte(req_ch.rx_byte);
            bytes_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
               // Starts an idle burst; its further length is drawn at random into send_gap.
               send_gap = $urandom_range(0, 18);
               req_ch.valid <= 1'b0;
            end else if (rx_bytes_pending.size() > 0) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= rx_bytes_pending.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every item taken is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      demux_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               flag_error($sformatf("Unexpected item: kind %0d data %02h index %0d seq %08h last %0d",
                                    rsp_ch.kind, rsp_ch.data_byte, rsp_ch.payload_index,
                                    rsp_ch.sequence_res, rsp_ch.last));
            end else begin
               want = results_due.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.data_byte !== want.data ||
                   rsp_ch.payload_index !== want.idx || rsp_ch.sequence_res !== want.seq ||
                   rsp_ch.last !== want.last) begin
                  flag_error($sformatf({"Item %0d: expected %s data %02h index %0d seq %08h ",
                                        "last %0d, got kind %0d data %02h index %0d seq %08h ",
                                        "last %0d"},
                                       results_seen, want.kind.name(), want.data, want.idx,
                                       want.seq, want.last, rsp_ch.kind, rsp_ch.data_byte,
                                       rsp_ch.payload_index, rsp_ch.sequence_res, rsp_ch.last));
               end
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            take_gap = $urandom_range(0, 18);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake or a lost item ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      rx_bytes_pending = {rx_bytes_pending, b};
      bytes_queued++;
   endtask

   // Queues a ten-byte header and returns the CRC over it.
   task automatic queue_header(input logic [7:0] ver, input logic [7:0] typ,
                               input logic [15:0] len_field, input logic [31:0] seq,
                               output logic [15:0] crc);
      logic [7:0] h [HEADER_BYTES];
      h[0] = SYNC_FIRST;
      h[1] = SYNC_SECOND;
      h[2] = ver;
      h[3] = typ;
      h[4] = len_field[7:0];
      h[5] = len_field[15:8];
      h[6] = seq[7:0];
      h[7] = seq[15:8];
      h[8] = seq[23:16];
      h[9] = seq[31:24];
      crc  = CRC_INIT;
      foreach (h[i]) begin
         queue_byte(h[i]);
         crc = crc16_next(crc, h[i]);
      end
   endtask

   task automatic queue_payload(input int count, inout logic [15:0] crc);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         b = rand_byte();
         queue_byte(b);
         crc = crc16_next(crc, b);
      end
   endtask

   // The CRC goes out low byte first; a spoilt one differs in at least one bit.
   task automatic queue_crc(input logic [15:0] crc, input bit spoil);
      logic [15:0] sent;
      sent = crc;
      if (spoil) begin
         sent = crc ^ 16'($urandom_range(1, 16'hFFFF));
      end
      queue_byte(sent[7:0]);
      queue_byte(sent[15:8]);
   endtask

   // A whole frame whose header matches the current register settings.
   task automatic queue_frame(input logic [31:0] seq, input bit spoil);
      logic [15:0] crc;
      queue_header(cfg_now.expected_version, cfg_now.expected_type,
                   16'(cfg_now.payload_length), seq, crc);
      queue_payload(int'(cfg_now.payload_length), crc);
      queue_crc(crc, spoil);
   endtask

   // Mostly well-formed frames with random content, the rest broken frames and loose bytes.
   task automatic queue_mixed_traffic(input int target);
      int          start;
      int          pick;
      logic [15:0] crc;
      logic [7:0]  v;
      logic [7:0]  t;
      logic [15:0] l;
      logic [7:0]  b;
      start = bytes_queued;
      while (bytes_queued - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            queue_frame($urandom, 1'b0);
         end else if (pick < 65) begin
            queue_frame($urandom, 1'b1);
         end else if (pick < 77) begin
            v = cfg_now.expected_version;
            t = cfg_now.expected_type;
            l = 16'(cfg_now.payload_length);
            case ($urandom_range(0, 2))
               0: v = v ^ 8'($urandom_range(1, 255));
               1: t = t ^ 8'($urandom_range(1, 255));
               default: l = l ^ 16'($urandom_range(1, 16'hFFFF));
            endcase
            queue_header(v, t, l, $urandom, crc);
         end else if (pick < 87) begin
            b = rand_byte();
            if (b == SYNC_SECOND) begin
               b = SYNC_FIRST;
            end
            queue_byte(SYNC_FIRST);
            queue_byte(b);
         end else begin
            repeat ($urandom_range(1, 4)) queue_byte(rand_byte());
         end
      end
   endtask

   task automatic write_reg(input sfld_csr_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LOG_ENABLE:       cfg_now.log_enable       = value[0];
         CSR_EXPECTED_VERSION: cfg_now.expected_version = value[7:0];
         CSR_EXPECTED_TYPE:    cfg_now.expected_type    = value[7:0];
         CSR_PAYLOAD_LENGTH:   cfg_now.payload_length   = value[INDEX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic enable, input logic [7:0] ver, input logic [7:0] typ,
                                 input logic [INDEX_W-1:0] len);
      write_reg(CSR_LOG_ENABLE, CSR_DATA_W'(enable));
      write_reg(CSR_EXPECTED_VERSION, CSR_DATA_W'(ver));
      write_reg(CSR_EXPECTED_TYPE, CSR_DATA_W'(typ));
      write_reg(CSR_PAYLOAD_LENGTH, CSR_DATA_W'(len));
      settings_used++;
   endtask

   // Waits until every byte has been taken and every expected item has come out, then lets the
   // block finish any header or CRC byte that causes no item.
   task automatic wait_quiet();
      while (bytes_accepted != bytes_queued || results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [15:0] crc;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_LOG_ENABLE;
      csr_wdata      = '0;
      src_gap_pct    = 10;
      sink_stall_pct = 10;

      // The predictor starts from the reset state of the block.
      hunt        = SEEK_FIRST;
      frame_count = '0;
      crc_run     = CRC_INIT;
      crc_low     = '0;
      seq_now     = '0;
      foreach (hdr_copy[i]) begin
         hdr_copy[i] = '0;
      end
      cfg_now.log_enable       = 1'b1;
      cfg_now.expected_version = 8'd1;
      cfg_now.expected_type    = 8'd1;
      cfg_now.payload_length   = 10'd324;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset settings: byte extremes, a false sync before an ordinary
      // byte, a header that misses the default length by one and one with the wrong type.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(SYNC_FIRST);
      queue_byte(8'h00);
      queue_header(8'd1, 8'd1, 16'd323, 32'h1234_5678, crc);
      queue_header(8'd1, 8'd2, 16'd324, 32'h8765_4321, crc);
      wait_quiet();

      // A short frame. Part way through its payload the length register is changed, which must
      // not shorten the frame, and logging is switched off, so the rest of the payload gives
      // nothing and the frame closes as dropped.
      apply_settings(1'b1, 8'd1, 8'd1, 10'd6);
      queue_header(8'd1, 8'd1, 16'd6, 32'hFFFF_FFFF, crc);
      queue_payload(3, crc);
      wait_quiet();
      write_reg(CSR_PAYLOAD_LENGTH, CSR_DATA_W'(1));
      write_reg(CSR_LOG_ENABLE, CSR_DATA_W'(0));
      queue_payload(3, crc);
      queue_crc(crc, 1'b0);
      wait_quiet();
      write_reg(CSR_LOG_ENABLE, CSR_DATA_W'(1));
      write_reg(CSR_PAYLOAD_LENGTH, CSR_DATA_W'(6));

      // A false sync on a repeated first sync byte that then opens a good frame.
      queue_byte(SYNC_FIRST);
      queue_frame(32'h0000_0000, 1'b0);
      wait_quiet();

      // Random traffic over a range of settings, the register extremes among them.
      apply_settings(1'b1, 8'($urandom), 8'($urandom), 10'($urandom_range(1, 8)));
      queue_mixed_traffic(30);
      wait_quiet();

      src_gap_pct    = 0;
      sink_stall_pct = 0;
      apply_settings(1'b1, 8'h00, 8'hFF, 10'd0);
      queue_mixed_traffic(25);
      wait_quiet();

      src_gap_pct    = 15;
      sink_stall_pct = 15;
      apply_settings(1'b0, 8'hFF, 8'h00, 10'd5);
      queue_mixed_traffic(25);
      wait_quiet();

      // Headers whose length lies beyond the longest payload that the block takes.
      src_gap_pct    = 5;
      sink_stall_pct = 5;
      apply_settings(1'b1, 8'($urandom), 8'($urandom), 10'd1023);
      queue_header(cfg_now.expected_version, cfg_now.expected_type, 16'hFFFF, $urandom, crc);
      queue_header(cfg_now.expected_version, cfg_now.expected_type, 16'd1024, $urandom, crc);
      wait_quiet();

      src_gap_pct    = 10;
      sink_stall_pct = 10;
      apply_settings(1'b1, 8'($urandom), 8'($urandom), 10'($urandom_range(1, 12)));
      queue_mixed_traffic(30);
      wait_quiet();

      // The closing stretch runs at full rate on both sides.
      src_gap_pct    = 0;
      sink_stall_pct = 0;
      apply_settings(1'b1, 8'($urandom), 8'($urandom), 10'($urandom_range(0, 6)));
      queue_mixed_traffic(25);
      wait_quiet();

      $display("Covered %0d received bytes and %0d checked items over %0d register settings.",
               bytes_accepted, results_seen, settings_used);
      $display("Frames closed: %0d good, %0d bad CRC, %0d dropped; %0d headers handed back.",
               frames_good, frames_bad, frames_dropped, headers_returned);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
